// ===== hw/rtl/gbdr_pkg.sv =====
// Shared constants and types for the gated baseline drift remover.
`default_nettype none

package gbdr_pkg;

    // Ring geometry
    localparam int WINDOW_DEPTH = 64;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = 7;
    localparam int DATA_W       = 32;
    localparam int SUM_W        = DATA_W + ADDR_W;

    // Divider retires two quotient bits per cycle
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_ITERS          = (SUM_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_ITERS + 1);
    localparam int DIV_W              = DIV_ITERS * DIV_BITS_PER_CYCLE;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CONC_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LWC_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0]         CONC_LEN_RST  = 7'd2;
    localparam logic [LEN_W-1:0]         LWC_LEN_RST   = 7'd2;
    localparam logic signed [DATA_W-1:0] THRESHOLD_RST = 32'sd655;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Which ring a push sequence works on
    typedef enum logic {
        RING_CONC,
        RING_LWC
    } ring_sel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbdr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module gbdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gated_baseline_drift_remover_core.sv =====
// Top level of the gated baseline drift remover: ring sequencer, divider and output register.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one water sample and one
//   concentration sample per transaction, each with its own valid flag.
//   Output channel (m_valid/m_ready) returns exactly one result per input
//   transaction, in order: the water sample plus the baseline average,
//   saturated signed Q16.16, with m_out_valid copying the water valid flag.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wr_data) take effect at
//   once; write them only while the block is idle. Index 3 is ignored.
// Sequencing:
//   One item at a time, with no ring push, one or both. A ring push is a RAM
//   read-modify-write (issue, update) plus the radix-4 divider (19 iterations,
//   then saturate and store). The next item is taken only after the result
//   has moved to the output register.
// Reset (aresetn low, synchronous): both rings read as zero through
//   per-entry valid bits, positions, sums and averages clear, registers
//   return to their defaults. No clearing pass is needed.
// Stall: a finished result waits in the output register; the next item is
//   taken meanwhile and holds in its final step until the register frees.
`default_nettype none

module gated_baseline_drift_remover_core
    import gbdr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Configuration
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_wr_data,
    // Input channel
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [DATA_W-1:0] s_lwc_sample,
    input  wire logic                     s_lwc_valid,
    input  wire logic signed [DATA_W-1:0] s_conc_sample,
    input  wire logic                     s_conc_valid,
    // Result channel
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_corrected_lwc,
    output logic                          m_out_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_UPDATE,
        ST_DIV,
        ST_GATE,
        ST_RESULT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic        [LEN_W-1:0]  conc_len_reg;
    logic        [LEN_W-1:0]  lwc_len_reg;
    logic signed [DATA_W-1:0] threshold_reg;

    // Latched input transaction
    logic signed [DATA_W-1:0] lwc_sample_reg;
    logic                     lwc_valid_reg;

    // Ring state
    logic [ADDR_W-1:0]        conc_pos_reg;
    logic [ADDR_W-1:0]        lwc_pos_reg;
    logic signed [SUM_W-1:0]  conc_sum_reg;
    logic signed [SUM_W-1:0]  lwc_sum_reg;
    logic signed [DATA_W-1:0] conc_avg_reg;
    logic signed [DATA_W-1:0] lwc_avg_reg;
    logic [WINDOW_DEPTH-1:0]  conc_filled_reg;
    logic [WINDOW_DEPTH-1:0]  lwc_filled_reg;

    // Push sequence
    ring_sel_t                sel_reg;
    logic signed [DATA_W-1:0] push_value_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [LEN_W-1:0]         len_reg;

    // Divider
    logic [DIV_W-1:0]         div_q_reg;
    logic [LEN_W-1:0]         div_rem_reg;
    logic                     div_neg_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;

    // Output register
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_corrected_reg;
    logic                     m_out_valid_reg;

    logic s_accept;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_corrected_lwc = m_corrected_reg;
    assign m_out_valid     = m_out_valid_reg;

    // Output register is free when empty or taken at this edge
    logic out_free;
    logic result_load;
    assign out_free    = !m_valid_reg || m_ready;
    assign result_load = (state_reg == ST_RESULT) && out_free;

    // Clamp a window length to 1..WINDOW_DEPTH
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if (len > LEN_W'(WINDOW_DEPTH)) begin
            r = LEN_W'(WINDOW_DEPTH);
        end
        return r;
    endfunction

    // Select the ring being pushed
    logic [LEN_W-1:0]         cur_len;
    logic [ADDR_W-1:0]        cur_pos;
    logic signed [SUM_W-1:0]  cur_sum;
    logic                     cur_filled;
    logic [LEN_W-1:0]         pos_inc;
    logic [ADDR_W-1:0]        pos_next;

    always_comb begin
        unique case (sel_reg)
            RING_CONC: begin
                cur_len    = eff_len(conc_len_reg);
                cur_pos    = conc_pos_reg;
                cur_sum    = conc_sum_reg;
                cur_filled = conc_filled_reg[addr_reg];
            end
            RING_LWC: begin
                cur_len    = eff_len(lwc_len_reg);
                cur_pos    = lwc_pos_reg;
                cur_sum    = lwc_sum_reg;
                cur_filled = lwc_filled_reg[addr_reg];
            end
            default: begin
                cur_len    = eff_len(conc_len_reg);
                cur_pos    = conc_pos_reg;
                cur_sum    = conc_sum_reg;
                cur_filled = conc_filled_reg[addr_reg];
            end
        endcase
    end

    // Pre-increment the position and wrap at the window length
    always_comb begin
        pos_inc  = {1'b0, cur_pos} + LEN_W'(1);
        pos_next = (pos_inc >= cur_len) ? '0 : pos_inc[ADDR_W-1:0];
    end

    // Rings
    logic [DATA_W-1:0] conc_rd_data;
    logic [DATA_W-1:0] lwc_rd_data;
    logic              conc_we;
    logic              lwc_we;

    assign conc_we = (state_reg == ST_UPDATE) && (sel_reg == RING_CONC);
    assign lwc_we  = (state_reg == ST_UPDATE) && (sel_reg == RING_LWC);

    gbdr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_conc_ring (
        .aclk    (aclk),
        .wr_en   (conc_we),
        .wr_addr (addr_reg),
        .wr_data (push_value_reg),
        .rd_addr (pos_next),
        .rd_data (conc_rd_data)
    );

    gbdr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_lwc_ring (
        .aclk    (aclk),
        .wr_en   (lwc_we),
        .wr_addr (addr_reg),
        .wr_data (push_value_reg),
        .rd_addr (pos_next),
        .rd_data (lwc_rd_data)
    );

    // Replace the old entry in the running sum; unwritten entries read as zero
    logic signed [DATA_W-1:0] old_entry;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     sum_neg;
    logic [SUM_W-1:0]         sum_mag;

    always_comb begin
        unique case (sel_reg)
            RING_CONC: old_entry = cur_filled ? conc_rd_data : '0;
            RING_LWC:  old_entry = cur_filled ? lwc_rd_data  : '0;
            default:   old_entry = '0;
        endcase
        sum_next = cur_sum - SUM_W'(old_entry) + SUM_W'(push_value_reg);
        sum_neg  = sum_next[SUM_W-1];
        sum_mag  = sum_neg ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    end

    // Divider step: two restoring steps per cycle
    logic [DIV_W-1:0] div_q_next;
    logic [LEN_W-1:0] div_rem_next;

    always_comb begin
        logic [LEN_W:0] trial;
        div_q_next   = div_q_reg;
        div_rem_next = div_rem_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            trial = {div_rem_next, div_q_next[DIV_W-1]};
            if (trial >= {1'b0, len_reg}) begin
                trial      = trial - {1'b0, len_reg};
                div_q_next = {div_q_next[DIV_W-2:0], 1'b1};
            end else begin
                div_q_next = {div_q_next[DIV_W-2:0], 1'b0};
            end
            div_rem_next = trial[LEN_W-1:0];
        end
    end

    // Apply the sign to the quotient and saturate to 32 bits
    logic signed [DATA_W-1:0] avg_sat;

    always_comb begin
        priority if (!div_neg_reg && div_q_reg > DIV_W'(Q_MAX)) begin
            avg_sat = Q_MAX;
        end else if (div_neg_reg && div_q_reg > DIV_W'(Q_MAX) + DIV_W'(1)) begin
            avg_sat = Q_MIN;
        end else if (div_neg_reg) begin
            avg_sat = DATA_W'(-div_q_reg);
        end else begin
            avg_sat = div_q_reg[DATA_W-1:0];
        end
    end

    // Baseline gate, negated water sample and corrected result
    logic                     gate_open;
    logic signed [DATA_W-1:0] lwc_neg;
    logic signed [DATA_W:0]   result_wide;
    logic signed [DATA_W-1:0] result_sat;

    always_comb begin
        gate_open   = (conc_avg_reg < threshold_reg) && lwc_valid_reg;
        lwc_neg     = (lwc_sample_reg == Q_MIN) ? Q_MAX : -lwc_sample_reg;
        result_wide = (DATA_W+1)'(lwc_sample_reg) + (DATA_W+1)'(lwc_avg_reg);
        priority if (result_wide > (DATA_W+1)'(Q_MAX)) begin
            result_sat = Q_MAX;
        end else if (result_wide < (DATA_W+1)'(Q_MIN)) begin
            result_sat = Q_MIN;
        end else begin
            result_sat = result_wide[DATA_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conc_len_reg  <= CONC_LEN_RST;
            lwc_len_reg   <= LWC_LEN_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CONC_LEN:  conc_len_reg  <= cfg_wr_data[LEN_W-1:0];
                REG_LWC_LEN:   lwc_len_reg   <= cfg_wr_data[LEN_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Sequencer, ring state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sel_reg         <= RING_CONC;
            conc_pos_reg    <= '0;
            lwc_pos_reg     <= '0;
            conc_sum_reg    <= '0;
            lwc_sum_reg     <= '0;
            conc_avg_reg    <= '0;
            lwc_avg_reg     <= '0;
            conc_filled_reg <= '0;
            lwc_filled_reg  <= '0;
            div_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Load a new result, or drop the one taken
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        lwc_sample_reg <= s_lwc_sample;
                        lwc_valid_reg  <= s_lwc_valid;
                        sel_reg        <= RING_CONC;
                        push_value_reg <= s_conc_sample;
                        state_reg      <= s_conc_valid ? ST_ISSUE : ST_GATE;
                    end
                end

                ST_ISSUE: begin
                    // Read the old entry at the advanced position
                    addr_reg  <= pos_next;
                    len_reg   <= cur_len;
                    state_reg <= ST_UPDATE;
                    unique case (sel_reg)
                        RING_CONC: conc_pos_reg <= pos_next;
                        RING_LWC:  lwc_pos_reg  <= pos_next;
                        default: ;
                    endcase
                end

                ST_UPDATE: begin
                    // Write back the new entry and start the average
                    unique case (sel_reg)
                        RING_CONC: begin
                            conc_sum_reg              <= sum_next;
                            conc_filled_reg[addr_reg] <= 1'b1;
                        end
                        RING_LWC: begin
                            lwc_sum_reg              <= sum_next;
                            lwc_filled_reg[addr_reg] <= 1'b1;
                        end
                        default: ;
                    endcase
                    div_q_reg   <= DIV_W'(sum_mag);
                    div_rem_reg <= '0;
                    div_neg_reg <= sum_neg;
                    div_cnt_reg <= DIV_CNT_W'(DIV_ITERS);
                    state_reg   <= ST_DIV;
                end

                ST_DIV: begin
                    if (div_cnt_reg != '0) begin
                        div_q_reg   <= div_q_next;
                        div_rem_reg <= div_rem_next;
                        div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                    end else begin
                        unique case (sel_reg)
                            RING_CONC: begin
                                conc_avg_reg <= avg_sat;
                                state_reg    <= ST_GATE;
                            end
                            RING_LWC: begin
                                lwc_avg_reg <= avg_sat;
                                state_reg   <= ST_RESULT;
                            end
                            default: state_reg <= ST_RESULT;
                        endcase
                    end
                end

                ST_GATE: begin
                    // Update the baseline only outside cloud
                    if (gate_open) begin
                        sel_reg        <= RING_LWC;
                        push_value_reg <= lwc_neg;
                        state_reg      <= ST_ISSUE;
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end

                ST_RESULT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_corrected_reg <= lwc_valid_reg ? result_sat : '0;
                        m_out_valid_reg <= lwc_valid_reg;
                        state_reg       <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== dv/gbdr_checker.sv =====
// Checker for the gated baseline drift remover: tracks the channels, predicts and compares.
`default_nettype none

module gbdr_checker
    import gbdr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_wr_data,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic signed [DATA_W-1:0] s_lwc_sample,
    input  wire logic                     s_lwc_valid,
    input  wire logic signed [DATA_W-1:0] s_conc_sample,
    input  wire logic                     s_conc_valid,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic signed [DATA_W-1:0] m_corrected_lwc,
    input  wire logic                     m_out_valid,
    output int                            mismatches,
    output int                            outstanding,
    output int                            results_checked,
    output int                            baseline_updates
);

    typedef struct packed {
        logic signed [DATA_W-1:0] corrected;
        logic                     present;
    } lwc_result_t;

    // Shadow of the block's registers
    logic [LEN_W-1:0]         conc_len_q;
    logic [LEN_W-1:0]         lwc_len_q;
    logic signed [DATA_W-1:0] threshold_q;

    // Both averaging rings, indexed by ring select
    longint ring_mem [2][WINDOW_DEPTH];
    int     ring_pos [2];
    longint ring_sum [2];
    longint ring_avg [2];

    lwc_result_t expected_q[$];
    int fail_cnt;
    int checked_cnt;
    int update_cnt;

    function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic int window_len(input logic [LEN_W-1:0] len_reg);
        if (len_reg == '0)
            return 1;
        if (int'(len_reg) > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return int'(len_reg);
    endfunction

    function automatic void clear_rings();
        for (int r = 0; r < 2; r++) begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
                ring_mem[r][i] = 0;
            ring_pos[r] = 0;
            ring_sum[r] = 0;
            ring_avg[r] = 0;
        end
    endfunction

    // Advance the write position, replace the oldest entry, refresh sum and average
    function automatic void push_entry(input ring_sel_t which, input logic [LEN_W-1:0] len_reg,
                                       input longint v);
        int len;
        int p;
        len = window_len(len_reg);
        p = ring_pos[which] + 1;
        if (p >= len || p >= WINDOW_DEPTH)
            p = 0;
        ring_pos[which] = p;
        ring_sum[which] = ring_sum[which] - ring_mem[which][p] + v;
        ring_mem[which][p] = v;
        ring_avg[which] = longint'(clamp_q(ring_sum[which] / longint'(len)));
    endfunction

    // Gate the baseline update on the concentration average and form the corrected sample
    function automatic lwc_result_t predict_corrected(input logic signed [DATA_W-1:0] lwc,
                                                      input logic lwc_ok,
                                                      input logic signed [DATA_W-1:0] conc,
                                                      input logic conc_ok);
        lwc_result_t r;
        longint lwc_l;
        lwc_l = longint'(lwc);
        if (conc_ok)
            push_entry(RING_CONC, conc_len_q, longint'(conc));
        if (ring_avg[RING_CONC] < longint'(threshold_q) && lwc_ok) begin
            push_entry(RING_LWC, lwc_len_q, longint'(clamp_q(-lwc_l)));
            update_cnt++;
        end
        r.present = lwc_ok;
        r.corrected = lwc_ok ? clamp_q(lwc_l + ring_avg[RING_LWC]) : '0;
        return r;
    endfunction

    function automatic void report_failure(input string what);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("[%0t] checker: %s", $realtime, what);
    endfunction

    initial begin
        fail_cnt = 0;
        checked_cnt = 0;
        update_cnt = 0;
        conc_len_q = CONC_LEN_RST;
        lwc_len_q = LWC_LEN_RST;
        threshold_q = THRESHOLD_RST;
        clear_rings();
        mismatches = 0;
        outstanding = 0;
        results_checked = 0;
        baseline_updates = 0;
    end

    always @(posedge aclk) begin : watch
        lwc_result_t exp_r;
        if (!aresetn) begin
            conc_len_q = CONC_LEN_RST;
            lwc_len_q = LWC_LEN_RST;
            threshold_q = THRESHOLD_RST;
            clear_rings();
            expected_q.delete();
        end else begin
            // Compare a result transaction with the oldest prediction
            if (m_valid && m_ready) begin
                checked_cnt++;
                if (expected_q.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with nothing pending: %0d/%0b",
                                             checked_cnt, m_corrected_lwc, m_out_valid));
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_corrected_lwc !== exp_r.corrected)
                        report_failure($sformatf("result %0d corrected_lwc expected %0d got %0d",
                                                 checked_cnt, exp_r.corrected, m_corrected_lwc));
                    if (m_out_valid !== exp_r.present)
                        report_failure($sformatf("result %0d out_valid expected %0b got %0b",
                                                 checked_cnt, exp_r.present, m_out_valid));
                end
            end
            // Predict for an input transaction
            if (s_valid && s_ready)
                expected_q.push_back(predict_corrected(s_lwc_sample, s_lwc_valid,
                                                       s_conc_sample, s_conc_valid));
            // Register writes land after this edge's transactions
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CONC_LEN:  conc_len_q = cfg_wr_data[LEN_W-1:0];
                    REG_LWC_LEN:   lwc_len_q = cfg_wr_data[LEN_W-1:0];
                    REG_THRESHOLD: threshold_q = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        mismatches <= fail_cnt;
        outstanding <= expected_q.size();
        results_checked <= checked_cnt;
        baseline_updates <= update_cnt;
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench top for the gated baseline drift remover: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
    import gbdr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RAND_PHASES      = 14;
    localparam int ITEMS_PER_PHASE  = 120;
    localparam int DRAIN_CYCLES     = 60;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_lwc_sample = '0;
    logic                     s_lwc_valid = 1'b0;
    logic signed [DATA_W-1:0] s_conc_sample = '0;
    logic                     s_conc_valid = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_corrected_lwc;
    logic                     m_out_valid;

    int  mismatches;
    int  outstanding;
    int  results_checked;
    int  baseline_updates;
    bit  no_idle = 1'b0;
    int  ready_hold = 0;
    int  sent_cnt = 0;
    int  setting_cnt = 0;

    gated_baseline_drift_remover_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_lwc_sample    (s_lwc_sample),
        .s_lwc_valid     (s_lwc_valid),
        .s_conc_sample   (s_conc_sample),
        .s_conc_valid    (s_conc_valid),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_corrected_lwc (m_corrected_lwc),
        .m_out_valid     (m_out_valid)
    );

    gbdr_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_lwc_sample     (s_lwc_sample),
        .s_lwc_valid      (s_lwc_valid),
        .s_conc_sample    (s_conc_sample),
        .s_conc_valid     (s_conc_valid),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_corrected_lwc  (m_corrected_lwc),
        .m_out_valid      (m_out_valid),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .results_checked  (results_checked),
        .baseline_updates (baseline_updates)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Bound the run well beyond the slowest legal schedule
    initial begin
        #8000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: hold off ready for a drawn number of cycles per transaction
    always @(posedge aclk) begin : result_side
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (m_ready) begin
            if (m_valid) begin
                gap = no_idle ? 0 : $urandom_range(0, 19);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    ready_hold <= gap;
                end
            end
        end else if (ready_hold <= 1) begin
            m_ready <= 1'b1;
            ready_hold <= 0;
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // Present one transaction after a drawn gap and hold it until accepted
    task automatic send_sample_pair(input logic signed [DATA_W-1:0] lwc, input logic lwc_ok,
                                    input logic signed [DATA_W-1:0] conc, input logic conc_ok);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_lwc_sample <= lwc;
        s_lwc_valid <= lwc_ok;
        s_conc_sample <= conc;
        s_conc_valid <= conc_ok;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
    endtask

    // Drop valid and wait until every result is back and the core has settled
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_wr_data <= data;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Length write with junk in the unused upper bits
    function automatic logic [DATA_W-1:0] len_word(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] w;
        w = $urandom;
        w[LEN_W-1:0] = len;
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return Q_MIN + 1;
            3: return Q_MAX - 1;
            4: return -1;
            5: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return LEN_W'($urandom_range(65, 127));
            4: return LEN_W'($urandom_range(1, 4));
            default: return LEN_W'($urandom_range(1, 64));
        endcase
    endfunction

    initial begin : stimulus
        logic [LEN_W-1:0]         conc_len;
        logic [LEN_W-1:0]         lwc_len;
        logic signed [DATA_W-1:0] thr;
        logic signed [DATA_W-1:0] lwc;
        logic signed [DATA_W-1:0] conc;
        int                       conc_center;
        int                       sel;
        bit                       heavy;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: small windows, threshold just above zero
        send_sample_pair(0, 1'b1, 0, 1'b1);
        send_sample_pair(Q_MAX, 1'b1, Q_MAX, 1'b1);
        send_sample_pair(Q_MIN, 1'b0, Q_MIN, 1'b0);
        send_sample_pair(1234, 1'b1, -5, 1'b0);
        send_sample_pair(-1, 1'b1, 1, 1'b1);

        // Open gate, fill the baseline with the saturated negation of the minimum
        wait_drained();
        cfg_write(REG_CONC_LEN, len_word(7'd4));
        cfg_write(REG_LWC_LEN, len_word(7'd4));
        cfg_write(REG_THRESHOLD, Q_MAX);
        setting_cnt++;
        repeat (4) send_sample_pair(Q_MIN, 1'b1, Q_MIN, 1'b1);
        send_sample_pair(Q_MAX, 1'b1, 0, 1'b0);

        // Shorten the baseline window: stale entries push the average past the range
        wait_drained();
        cfg_write(REG_LWC_LEN, len_word(7'd1));
        setting_cnt++;
        send_sample_pair(Q_MIN, 1'b1, Q_MIN, 1'b1);
        send_sample_pair(Q_MAX, 1'b1, 0, 1'b0);

        // Zero and oversized lengths, closed gate, write to the unused index
        wait_drained();
        cfg_write(REG_CONC_LEN, len_word(7'd0));
        cfg_write(REG_LWC_LEN, len_word(7'd127));
        cfg_write(REG_THRESHOLD, Q_MIN);
        cfg_write(REG_UNUSED, $urandom);
        setting_cnt++;
        send_sample_pair(-1, 1'b1, Q_MIN, 1'b1);
        send_sample_pair(Q_MAX, 1'b1, Q_MAX, 1'b1);

        wait_drained();
        cfg_write(REG_THRESHOLD, 0);
        cfg_write(REG_LWC_LEN, len_word(7'd64));
        setting_cnt++;
        send_sample_pair(5, 1'b1, -1, 1'b1);
        send_sample_pair(Q_MIN, 1'b1, 1, 1'b1);
        send_sample_pair(Q_MIN, 1'b1, -2, 1'b1);
        send_sample_pair(100, 1'b0, -3, 1'b1);

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            conc_len = pick_len();
            lwc_len = pick_len();
            heavy = (ph % 5 == 4);
            case ($urandom_range(0, 5))
                0: thr = Q_MIN;
                1: thr = Q_MAX;
                2: thr = $urandom;
                default: thr = $signed($urandom_range(0, 6000)) - 3000;
            endcase
            conc_center = (thr > -100000 && thr < 100000) ? int'(thr) : 0;
            cfg_write(REG_CONC_LEN, len_word(conc_len));
            cfg_write(REG_LWC_LEN, len_word(lwc_len));
            cfg_write(REG_THRESHOLD, thr);
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_UNUSED, $urandom);
            setting_cnt++;
            no_idle <= (ph % 4 == 3);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Concentration mostly straddles the threshold so the gate toggles
                sel = $urandom_range(0, 99);
                if (heavy ? sel < 70 : sel < 15)
                    conc = pick_extreme();
                else if (sel < 85)
                    conc = conc_center + $signed($urandom_range(0, 4000)) - 2000;
                else
                    conc = $urandom;
                sel = $urandom_range(0, 99);
                if (heavy ? sel < 70 : sel < 20)
                    lwc = pick_extreme();
                else if (sel < 70)
                    lwc = $signed($urandom_range(0, 200000)) - 100000;
                else
                    lwc = $urandom;
                send_sample_pair(lwc, $urandom_range(0, 99) < 85, conc,
                                 $urandom_range(0, 99) < 80);
            end
        end

        wait_drained();

        $display("covered %0d transactions over %0d register settings", sent_cnt, setting_cnt);
        $display("checked %0d results, %0d of which updated the baseline ring",
                 results_checked, baseline_updates);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, outstanding);
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
